// ----- hw/rtl/adc_scan_auto_gain_top_macros.svh -----
// Assertion macros for the converter scan block checkers.
`ifndef ADC_SCAN_AUTO_GAIN_TOP_MACROS_SVH
`define ADC_SCAN_AUTO_GAIN_TOP_MACROS_SVH

// checked only out of reset
`define ASG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define ASG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- hw/rtl/asg_pkg.sv -----
// Package: shared constants, codes and types of the converter scan block.
`default_nettype none
package asg_pkg;
    localparam int GAIN_STEPS = 5;
    localparam int GAIN_W     = 3;
    localparam int SAMPLE_W   = 17;
    localparam int MEAS_W     = 15;
    localparam int THR_W      = 16;
    localparam int CH_W       = 2;
    localparam int NUM_CH     = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(GAIN_STEPS - 1);
    localparam logic [GAIN_W-1:0] GAIN_RST = (GAIN_STEPS - 1 < 4) ? GAIN_W'(GAIN_STEPS - 1)
                                                                  : GAIN_W'(4);
    localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(NUM_CH - 1);
    localparam logic [CH_W-1:0]   CH_SHUNT  = '0;
    localparam logic [THR_W-1:0]  UPPER_RST = 16'h7000;
    localparam logic [THR_W-1:0]  LOWER_RST = 16'h1000;

    typedef enum logic [1:0] {
        OP_CONV  = 2'd0,
        OP_FETCH = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER = 1'b0,
        CFG_LOWER = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic walk;
        logic load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic scan_complete;
        logic walk_last;
    } t_status;
endpackage
`default_nettype wire

// ----- hw/rtl/asg_in_if.sv -----
// Input channel interface: operation word with conversion sample.
`default_nettype none
interface asg_in_if import asg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    t_op                        op;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, op, sample_value, input ready);
    modport sink (input valid, op, sample_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/asg_out_if.sv -----
// Output channel interface: channel select, flags, scaled measurements, gain.
`default_nettype none
interface asg_out_if import asg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          next_channel;
    logic                     differential_mode;
    logic                     start_next;
    logic                     fetched;
    logic signed [MEAS_W-1:0] meas_current;
    logic signed [MEAS_W-1:0] meas_battery;
    logic signed [MEAS_W-1:0] meas_output;
    logic signed [MEAS_W-1:0] meas_temperature;
    logic [GAIN_W-1:0]        gain_code;

    modport source (output valid, next_channel, differential_mode, start_next, fetched,
                    meas_current, meas_battery, meas_output, meas_temperature, gain_code,
                    input ready);
    modport sink (input valid, next_channel, differential_mode, start_next, fetched,
                  meas_current, meas_battery, meas_output, meas_temperature, gain_code,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/asg_ctrl.sv -----
// Controller: sequences accept, execute, sample walk and result load.
`default_nettype none
module asg_ctrl import asg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_status i_status,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.op == OP_FETCH && i_status.scan_complete) n_state = S_WALK;
                else n_state = S_LOAD;
            end
            S_WALK: begin
                if (i_status.walk_last) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.walk   = (r_state == S_WALK);
        o_cmd.load   = (r_state == S_LOAD) && out_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.load) n_out_valid = 1'b1;
        else if (i_out_ready)    n_out_valid = 1'b0;
        else                     n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ----- hw/rtl/asg_dp.sv -----
// Datapath: sample store, channel and flag state, scaling unit, gain ranging.
`default_nettype none
module asg_dp import asg_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    output t_status                         o_status,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [THR_W-1:0]           i_cfg_data,
    input  wire t_op                        i_op,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic [CH_W-1:0]                 o_next_channel,
    output logic                            o_differential_mode,
    output logic                            o_start_next,
    output logic                            o_fetched,
    output logic signed [MEAS_W-1:0]        o_meas_current,
    output logic signed [MEAS_W-1:0]        o_meas_battery,
    output logic signed [MEAS_W-1:0]        o_meas_output,
    output logic signed [MEAS_W-1:0]        o_meas_temperature,
    output logic [GAIN_W-1:0]               o_gain_code
);
    logic [THR_W-1:0]           r_upper;
    logic [THR_W-1:0]           r_lower;
    logic [CH_W-1:0]            r_chan;
    logic signed [SAMPLE_W-1:0] r_store [NUM_CH];
    logic                       r_complete;
    logic [GAIN_W-1:0]          r_gain;

    t_op                        r_op;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_start;
    logic                       r_got;
    logic [CH_W-1:0]            r_idx;
    logic signed [MEAS_W-1:0]   r_meas [NUM_CH];

    logic [CH_W-1:0]            r_o_chan;
    logic                       r_o_diff;
    logic                       r_o_start;
    logic                       r_o_got;
    logic signed [MEAS_W-1:0]   r_o_meas [NUM_CH];
    logic [GAIN_W-1:0]          r_o_gain;

    // scaling unit, one stored sample per cycle
    logic signed [SAMPLE_W-1:0] rd;
    logic signed [MEAS_W-1:0]   sh;
    logic signed [MEAS_W:0]     bias;
    logic signed [MEAS_W:0]     sum;
    logic signed [MEAS_W:0]     quo;
    logic signed [MEAS_W-1:0]   scaled;
    logic [SAMPLE_W-1:0]        mag;
    logic                       go_down;
    logic                       go_up;

    always_comb begin
        rd     = r_store[r_idx];
        sh     = MEAS_W'(rd >>> 2);
        bias   = sh[MEAS_W-1] ? (MEAS_W+1)'((1 << r_gain) - 1) : '0;
        sum    = {sh[MEAS_W-1], sh} + bias;
        quo    = sum >>> r_gain;
        scaled = (r_idx == CH_SHUNT) ? quo[MEAS_W-1:0] : sh;
        mag    = rd[SAMPLE_W-1] ? SAMPLE_W'(-rd) : rd;
        go_down = mag > {1'b0, r_upper};
        go_up   = mag < {1'b0, r_lower};
    end

    assign o_status.op            = r_op;
    assign o_status.scan_complete = r_complete;
    assign o_status.walk_last     = (r_idx == CH_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper    <= UPPER_RST;
            r_lower    <= LOWER_RST;
            r_chan     <= '0;
            r_complete <= 1'b0;
            r_gain     <= GAIN_RST;
            for (int k = 0; k < NUM_CH; k++) r_store[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_UPPER: r_upper <= i_cfg_data;
                    CFG_LOWER: r_lower <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                unique case (r_op)
                    OP_CONV: begin
                        r_store[r_chan] <= r_sample;
                        if (r_chan == CH_LAST) begin
                            r_complete <= 1'b1;
                            r_chan     <= '0;
                        end else begin
                            r_chan <= r_chan + 1'b1;
                        end
                    end
                    OP_START: r_complete <= 1'b0;
                    OP_FETCH: ;
                    OP_NONE: ;
                    default: ;
                endcase
            end
            // ranging uses the raw shunt sample, after its scaling used the old gain
            if (i_cmd.walk && r_idx == CH_SHUNT) begin
                priority if (go_down) begin
                    if (r_gain != '0) r_gain <= r_gain - 1'b1;
                end else if (go_up) begin
                    if (r_gain != GAIN_MAX) r_gain <= r_gain + 1'b1;
                end else begin
                    r_gain <= r_gain;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_op;
            r_sample <= i_sample_value;
        end
        if (i_cmd.exec) begin
            r_start <= (r_op == OP_START) || (r_op == OP_CONV && r_chan != CH_LAST);
            r_got   <= (r_op == OP_FETCH) && r_complete;
            r_idx   <= '0;
        end
        if (i_cmd.walk) begin
            r_meas[r_idx] <= scaled;
            r_idx         <= r_idx + 1'b1;
        end
        if (i_cmd.load) begin
            r_o_chan  <= r_chan;
            r_o_diff  <= (r_chan == CH_SHUNT);
            r_o_start <= r_start;
            r_o_got   <= r_got;
            r_o_gain  <= r_gain;
            for (int k = 0; k < NUM_CH; k++) r_o_meas[k] <= r_got ? r_meas[k] : '0;
        end
    end

    assign o_next_channel      = r_o_chan;
    assign o_differential_mode = r_o_diff;
    assign o_start_next        = r_o_start;
    assign o_fetched           = r_o_got;
    assign o_meas_current      = r_o_meas[0];
    assign o_meas_battery      = r_o_meas[1];
    assign o_meas_output       = r_o_meas[2];
    assign o_meas_temperature  = r_o_meas[3];
    assign o_gain_code         = r_o_gain;
endmodule
`default_nettype wire

// ----- hw/rtl/adc_scan_auto_gain_top.sv -----
// Path: conversion, start and unused words, and fetches before a completed scan, pass from
// accept through the execute and load states to the output register; a fetch on a completed
// scan first walks the four stored samples, one per cycle through a single shift/gain scaling unit.
// Flow: one word in work at a time; the next is taken once the result is registered,
// even if it stalls.
// Reset (synchronous, active low): channel 0, samples and scan flag cleared,
// gain code 4, thresholds 0x7000 and 0x1000, output empty.
`default_nettype none
module adc_scan_auto_gain_top import asg_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [THR_W-1:0]     i_cfg_data,
    asg_in_if.sink                    i_in,
    asg_out_if.source                 o_out
);
    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;

    asg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (status),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    asg_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_op                (i_in.op),
        .i_sample_value      (i_in.sample_value),
        .o_next_channel      (o_out.next_channel),
        .o_differential_mode (o_out.differential_mode),
        .o_start_next        (o_out.start_next),
        .o_fetched           (o_out.fetched),
        .o_meas_current      (o_out.meas_current),
        .o_meas_battery      (o_out.meas_battery),
        .o_meas_output       (o_out.meas_output),
        .o_meas_temperature  (o_out.meas_temperature),
        .o_gain_code         (o_out.gain_code)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
endmodule
`default_nettype wire

// ----- hw/rtl/asg_checker.sv -----
// Checker on the top level output port, with its bind.
`default_nettype none
`include "adc_scan_auto_gain_top_macros.svh"
module asg_checker import asg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    asg_out_if.source o_out
);
    `ASG_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out.valid, "output valid after reset")
    `ASG_ASSERT(a_hold, o_out.valid && !o_out.ready |=> o_out.valid, "stalled word dropped")
    `ASG_ASSERT(a_meas_zero, o_out.valid && !o_out.fetched |-> o_out.meas_current == '0 && o_out.meas_battery == '0 && o_out.meas_output == '0 && o_out.meas_temperature == '0, "meas nonzero without fetch")
    `ASG_ASSERT(a_diff, o_out.valid |-> o_out.differential_mode == (o_out.next_channel == CH_SHUNT), "mode mismatch")
    `ASG_ASSERT(a_gain, o_out.valid |-> o_out.gain_code <= GAIN_MAX && !(o_out.fetched && o_out.start_next), "gain or flags out of range")
endmodule

bind adc_scan_auto_gain_top asg_checker u_asg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_out   (o_out)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the four-channel converter scan with automatic gain ranging.
module testbench import asg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 320;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] sample;
    } scan_word_t;

    typedef struct packed {
        logic [CH_W-1:0]          next_channel;
        logic                     differential_mode;
        logic                     start_next;
        logic                     fetched;
        logic signed [MEAS_W-1:0] meas_current;
        logic signed [MEAS_W-1:0] meas_battery;
        logic signed [MEAS_W-1:0] meas_output;
        logic signed [MEAS_W-1:0] meas_temperature;
        logic [GAIN_W-1:0]        gain_code;
    } scan_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [THR_W-1:0]     i_cfg_data;

    asg_in_if  in_if ();
    asg_out_if out_if ();

    adc_scan_auto_gain_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [CH_W-1:0]            ch_sel;
    logic signed [SAMPLE_W-1:0] samples [NUM_CH];
    logic                       scan_done;
    logic [GAIN_W-1:0]          gain;
    int                         thr_upper;
    int                         thr_lower;

    scan_word_t   pending_words [$];
    scan_result_t expected_results [$];
    int           queued_count   = 0;
    int           accepted_count = 0;
    int           err_count      = 0;
    int           cycle_count    = 0;
    int           idle_odds      = 0;
    int           src_gap        = 0;
    int           sink_gap       = 0;
    int           hold_left      = -1;
    bit           hold_req       = 1'b0;
    bit           in_taken       = 1'b0;

    function automatic scan_result_t predict_scan_step(t_op op, logic signed [SAMPLE_W-1:0] s);
        scan_result_t r;
        int cur;
        int mag;
        r = '0;
        case (op)
            OP_CONV: begin
                samples[ch_sel] = s;
                if (ch_sel == CH_LAST) begin
                    scan_done = 1'b1;
                    ch_sel = CH_SHUNT;
                end else begin
                    r.start_next = 1'b1;
                    ch_sel = ch_sel + 1'b1;
                end
            end
            OP_FETCH: begin
                if (scan_done) begin
                    cur = samples[0];
                    mag = (cur < 0) ? -cur : cur;
                    r.fetched = 1'b1;
                    r.meas_current     = MEAS_W'((cur >>> 2) / (1 << gain));
                    r.meas_battery     = MEAS_W'(samples[1] >>> 2);
                    r.meas_output      = MEAS_W'(samples[2] >>> 2);
                    r.meas_temperature = MEAS_W'(samples[3] >>> 2);
                    if (mag > thr_upper) begin
                        if (gain > 0) gain = gain - 1'b1;
                    end else if (mag < thr_lower) begin
                        if (gain < GAIN_MAX) gain = gain + 1'b1;
                    end
                end
            end
            OP_START: begin
                r.start_next = 1'b1;
                scan_done = 1'b0;
            end
            default: ;
        endcase
        r.next_channel      = ch_sel;
        r.differential_mode = (ch_sel == CH_SHUNT);
        r.gain_code         = gain;
        return r;
    endfunction

    // biased toward the thresholds, small values and the range ends
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int up, int lo);
        int m;
        case ($urandom_range(0, 4))
            0: return SAMPLE_W'($urandom);
            1: m = up + $urandom_range(0, 2) - 1;
            2: m = lo + $urandom_range(0, 2) - 1;
            3: m = $urandom_range(0, 15);
            default: begin
                case ($urandom_range(0, 3))
                    0: m = -65536;
                    1: m = 65535;
                    2: m = -1;
                    default: m = 0;
                endcase
                return SAMPLE_W'(m);
            end
        endcase
        if ($urandom_range(0, 1) == 1) m = -m;
        if (m > 65535) m = 65535;
        if (m < -65536) m = -65536;
        return SAMPLE_W'(m);
    endfunction

    task automatic queue_word(t_op op, logic signed [SAMPLE_W-1:0] s);
        pending_words.push_back('{op: op, sample: s});
        queued_count++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin : driver
        scan_word_t w;
        if (!in_if.valid || in_taken) begin
            if (src_gap != 0) begin
                src_gap = src_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                in_if.valid        <= 1'b1;
                in_if.op           <= w.op;
                in_if.sample_value <= w.sample;
                if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    src_gap = $urandom_range(1, 7);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold-off on request
    always @(negedge i_clk) begin : receiver
        if (hold_req && hold_left < 0)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap = sink_gap - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                sink_gap = $urandom_range(1, 7);
        end
    end

    always @(posedge i_clk) begin : monitor
        scan_result_t got;
        scan_result_t want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got = '{out_if.next_channel, out_if.differential_mode, out_if.start_next,
                        out_if.fetched, out_if.meas_current, out_if.meas_battery,
                        out_if.meas_output, out_if.meas_temperature, out_if.gain_code};
                if (expected_results.size() == 0) begin
                    report_mismatch("word with nothing expected", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.next_channel !== want.next_channel)
                        report_mismatch("next_channel", got.next_channel, want.next_channel);
                    if (got.differential_mode !== want.differential_mode)
                        report_mismatch("differential_mode", got.differential_mode,
                                        want.differential_mode);
                    if (got.start_next !== want.start_next)
                        report_mismatch("start_next", got.start_next, want.start_next);
                    if (got.fetched !== want.fetched)
                        report_mismatch("fetched", got.fetched, want.fetched);
                    if (got.meas_current !== want.meas_current)
                        report_mismatch("meas_current", got.meas_current, want.meas_current);
                    if (got.meas_battery !== want.meas_battery)
                        report_mismatch("meas_battery", got.meas_battery, want.meas_battery);
                    if (got.meas_output !== want.meas_output)
                        report_mismatch("meas_output", got.meas_output, want.meas_output);
                    if (got.meas_temperature !== want.meas_temperature)
                        report_mismatch("meas_temperature", got.meas_temperature,
                                        want.meas_temperature);
                    if (got.gain_code !== want.gain_code)
                        report_mismatch("gain_code", got.gain_code, want.gain_code);
                end
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                in_taken = 1'b1;
                accepted_count++;
                expected_results.push_back(predict_scan_step(in_if.op, in_if.sample_value));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int up;
        int lo;
        int base;
        int n;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_UPPER;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.op           = OP_NONE;
        in_if.sample_value = '0;
        out_if.ready       = 1'b0;
        ch_sel    = CH_SHUNT;
        scan_done = 1'b0;
        gain      = GAIN_RST;
        thr_upper = int'(UPPER_RST);
        thr_lower = int'(LOWER_RST);
        foreach (samples[k]) samples[k] = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fetch before completion, idle code, full scans at the range ends
        idle_odds = 4;
        queue_word(OP_FETCH, '0);
        queue_word(OP_NONE, SAMPLE_W'(-1));
        queue_word(OP_START, '0);
        queue_word(OP_CONV, SAMPLE_W'(-65536));
        queue_word(OP_CONV, SAMPLE_W'(65535));
        queue_word(OP_CONV, SAMPLE_W'(-1));
        queue_word(OP_CONV, SAMPLE_W'(-3));
        queue_word(OP_FETCH, '0);
        queue_word(OP_FETCH, SAMPLE_W'(65535));
        queue_word(OP_NONE, '0);
        queue_word(OP_START, '0);
        queue_word(OP_FETCH, '0);
        queue_word(OP_CONV, SAMPLE_W'(0));
        queue_word(OP_CONV, SAMPLE_W'(-5));
        queue_word(OP_CONV, SAMPLE_W'(5));
        queue_word(OP_CONV, SAMPLE_W'(1));
        queue_word(OP_FETCH, '0);
        queue_word(OP_CONV, SAMPLE_W'(-7));
        queue_word(OP_CONV, SAMPLE_W'(65535));
        queue_word(OP_CONV, SAMPLE_W'(-65536));
        queue_word(OP_CONV, SAMPLE_W'(2));
        queue_word(OP_FETCH, '0);
        queue_word(OP_CONV, SAMPLE_W'(-28673));
        queue_word(OP_START, '0);
        queue_word(OP_FETCH, '0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    up = int'(UPPER_RST);
                    lo = int'(LOWER_RST);
                end
                1: begin
                    up = 0;
                    lo = 0;
                end
                2: begin
                    up = 65535;
                    lo = 65535;
                end
                3: begin
                    up = $urandom_range(0, 65535);
                    lo = $urandom_range(0, up);
                end
                4: begin
                    up = 256;
                    lo = 65535;
                end
                default: begin
                    up = $urandom_range(4096, 40000);
                    lo = $urandom_range(0, 8192);
                end
            endcase
            idle_odds = (p == 3 || p == PHASES - 1) ? 0 : 2 + p;

            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_UPPER;
            i_cfg_data <= THR_W'(up);
            thr_upper = up;
            @(negedge i_clk);
            i_cfg_idx  <= CFG_LOWER;
            i_cfg_data <= THR_W'(lo);
            thr_lower = lo;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            // mostly complete scans with fetches, some stray words
            base = queued_count;
            while (queued_count - base < PHASE_WORDS) begin
                if ($urandom_range(0, 9) < 8) begin
                    if ($urandom_range(0, 2) == 0)
                        queue_word(OP_START, SAMPLE_W'($urandom));
                    for (int k = 0; k < NUM_CH; k++)
                        queue_word(OP_CONV, pick_sample(up, lo));
                    n = $urandom_range(1, 3);
                    repeat (n) queue_word(OP_FETCH, SAMPLE_W'($urandom));
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) queue_word(t_op'($urandom_range(0, 3)), pick_sample(up, lo));
                end
            end
            if (p == 1)
                hold_req = 1'b1;
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
